// ----- hw/rtl/sha1bs_pkg.sv -----
`timescale 1ns / 1ps
package sha1bs_pkg;
  localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] K_GRP [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                        32'hCA62C1D6};
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;
endpackage

// ----- hw/rtl/sha1bs_front.sv -----
`timescale 1ns / 1ps
module sha1bs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha1bs_pkg::item_t  in_item,
  output logic               q_valid,
  input  logic               q_pop,
  output sha1bs_pkg::item_t  q_item
);
  import sha1bs_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  // empty items are dropped here
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_item.present || in_item.last);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("push into full queue");
endmodule

// ----- hw/rtl/sha1bs_core.sv -----
`timescale 1ns / 1ps
module sha1bs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  sha1bs_pkg::item_t  q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  import sha1bs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RND  = 6'b000010,
    S_ADD  = 6'b000100,
    S_PAD  = 6'b001000,
    S_LEN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t      st_r, st_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] bits_r;
  logic [5:0]  fill_r;
  logic [6:0]  rnd_r;
  logic        fin_r;
  logic        len_r;
  logic        pend_r;
  logic [2:0]  oidx_r;
  logic [31:0] wt, f, kt, tmp, wx;
  logic [1:0]  grp;
  logic [3:0]  wi;
  logic [31:0] put_val;
  logic [7:0]  put_b;
  logic        put_en;

  assign grp = (rnd_r < 7'd20) ? 2'd0 : (rnd_r < 7'd40) ? 2'd1 :
               (rnd_r < 7'd60) ? 2'd2 : 2'd3;
  assign kt  = K_GRP[grp];
  assign wx  = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wt  = (rnd_r < 7'd16) ? w_r[0] : {wx[30:0], wx[31]};
  always_comb begin
    case (grp)
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd2:    f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f = b_r ^ c_r ^ d_r;
    endcase
  end
  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + kt + wt;

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid       = (st_r == S_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd4);

  // byte write into the block buffer
  assign wi = fill_r[5:2];
  always_comb begin
    put_en = 1'b0;
    put_b  = 8'h00;
    if (q_pop && q_item.present) begin
      put_en = 1'b1;
      put_b  = q_item.data;
    end else if (st_r == S_PAD) begin
      put_en = 1'b1;
      put_b  = fin_r ? 8'h00 : PAD_MARK;
    end
    put_val = w_r[wi];
    case (fill_r[1:0])
      2'd0:    put_val[31:24] = put_b;
      2'd1:    put_val[23:16] = put_b;
      2'd2:    put_val[15:8]  = put_b;
      default: put_val[7:0]   = put_b;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_pop) begin
        if (q_item.present && fill_r == 6'd63) st_nxt = S_RND;
        else if (q_item.last) st_nxt = S_PAD;
      end
      S_RND:  if (rnd_r == 7'd79) st_nxt = S_ADD;
      S_ADD:  st_nxt = len_r ? S_OUT : (fin_r || pend_r) ? S_PAD : S_IDLE;
      S_PAD:  if (fill_r == 6'd63) st_nxt = S_RND;
              else if (fill_r == 6'd55) st_nxt = S_LEN;
      S_LEN:  st_nxt = S_RND;
      S_OUT:  if (!out_stall && oidx_r == 3'd4) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (put_en) w_r[wi] <= put_val;
    if (st_r == S_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wt;
    end
    if (st_r == S_LEN) begin
      w_r[14] <= bits_r[63:32];
      w_r[15] <= bits_r[31:0];
    end
    if (!rst_n) begin
      st_r   <= S_IDLE;
      for (int i = 0; i < 5; i++) h_r[i] <= H_INIT[i];
      bits_r <= 64'd0;
      fill_r <= 6'd0;
      rnd_r  <= 7'd0;
      fin_r  <= 1'b0;
      len_r  <= 1'b0;
      pend_r <= 1'b0;
      oidx_r <= 3'd0;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop && q_item.present) begin
        bits_r <= bits_r + 64'd8;
        fill_r <= fill_r + 6'd1;
      end
      if (q_pop && q_item.last) fin_r <= 1'b0;
      // last beat that also fills the block pads after the compression
      if (q_pop && q_item.present && q_item.last && fill_r == 6'd63) pend_r <= 1'b1;
      if (st_r == S_PAD) begin
        fill_r <= (st_nxt == S_LEN) ? 6'd0 : fill_r + 6'd1;
        fin_r  <= 1'b1;
        pend_r <= 1'b0;
      end
      if (st_nxt == S_RND && st_r != S_RND) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        rnd_r <= 7'd0;
        if (st_r == S_LEN) len_r <= 1'b1;
      end
      if (st_r == S_IDLE && q_pop && q_item.last) len_r <= 1'b0;
      if (st_r == S_RND) begin
        e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= tmp;
        rnd_r <= rnd_r + 7'd1;
      end
      if (st_r == S_ADD) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
        oidx_r <= 3'd0;
      end
      if (st_r == S_OUT && !out_stall) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd4) begin
          for (int i = 0; i < 5; i++) h_r[i] <= H_INIT[i];
          bits_r <= 64'd0;
          fill_r <= 6'd0;
          len_r  <= 1'b0;
          fin_r  <= 1'b0;
        end
      end
    end
  end

  a_oidx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> oidx_r <= 3'd4) else $error("digest index out of range");
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RND) |-> rnd_r < 7'd80) else $error("round counter overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(oidx_r))
    else $error("result dropped under stall");
endmodule

// ----- hw/rtl/sha1_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// sha-1 hasher fed one message byte per beat
// input channel: in_data_byte, in_byte_present, in_last_byte with in_valid/in_stall
// a beat with in_last_byte set ends the message, its byte counts if present
// a beat with neither present nor last is dropped
// result channel: five beats per message, h0..h4, out_last_word on h4
// a two-entry queue sits between the input side and the hashing core
// a byte beat is normally taken while the core is idle; the 64th byte of a block
// starts the round loop and then the add step, during which no bytes are taken
// a last beat adds padding writes, one or two compressions,
// then five result beats
// out_stall holds the current digest word; the core waits, the queue fills,
// then in_stall rises
// synchronous reset loads the sha-1 initial chaining values and empties the queue
module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1bs_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  assign in_item = '{data: in_data_byte, present: in_byte_present, last: in_last_byte};

  sha1bs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_valid, .q_pop, .q_item
  );

  sha1bs_core u_core (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
